@@ hdl/ppmd_pkg.sv @@
// Shared types and constants of the PPM pulse train decoder.
// No dependencies; every other file but ppmd_checker imports it.
package ppmd_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int COUNT_BITS     = 5;
   localparam int WIDTH_BITS     = 16;
   localparam int TIME_BITS      = 24;
   localparam int READ_BITS      = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIN_WIDTH     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_WIDTH     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_GAP     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOSS_TIMEOUT  = 3'd4;

   localparam logic [COUNT_BITS-1:0] RESET_CHANNEL_COUNT = 5'd8;
   localparam logic [WIDTH_BITS-1:0] RESET_MIN_WIDTH     = 16'd900;
   localparam logic [WIDTH_BITS-1:0] RESET_MAX_WIDTH     = 16'd2100;
   localparam logic [TIME_BITS-1:0]  RESET_FRAME_GAP     = 24'd3000;
   localparam logic [TIME_BITS-1:0]  RESET_LOSS_TIMEOUT  = 24'd100000;

   typedef struct packed {
      logic                 line_level;
      logic [READ_BITS-1:0] read_channel;
      logic                 acknowledge;
   } req_item_type;

   typedef struct packed {
      logic                  ready_res;
      logic                  signal_lost;
      logic [WIDTH_BITS-1:0] read_value;
      logic                  width_stored;
      logic                  sync_seen;
   } rsp_item_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] channel_count;
      logic [WIDTH_BITS-1:0] min_width;
      logic [WIDTH_BITS-1:0] max_width;
      logic [TIME_BITS-1:0]  frame_gap;
      logic [TIME_BITS-1:0]  loss_timeout;
   } csr_regs_type;

endpackage

@@ hdl/ppmd_csr.sv @@
// Configuration register bank of the PPM decoder.
// Depends on ppmd_pkg.
module ppmd_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [ppmd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ppmd_pkg::CSR_DATA_BITS-1:0]    csr_write_data,
   output ppmd_pkg::csr_regs_type                regs
);
   import ppmd_pkg::*;

   csr_regs_type regs_ff;
   csr_regs_type regs_in;

   always_comb begin
      regs_in = regs_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHANNEL_COUNT: regs_in.channel_count = csr_write_data[COUNT_BITS-1:0];
            CSR_MIN_WIDTH:     regs_in.min_width     = csr_write_data[WIDTH_BITS-1:0];
            CSR_MAX_WIDTH:     regs_in.max_width     = csr_write_data[WIDTH_BITS-1:0];
            CSR_FRAME_GAP:     regs_in.frame_gap     = csr_write_data[TIME_BITS-1:0];
            CSR_LOSS_TIMEOUT:  regs_in.loss_timeout  = csr_write_data[TIME_BITS-1:0];
            default:           regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.channel_count <= RESET_CHANNEL_COUNT;
         regs_ff.min_width     <= RESET_MIN_WIDTH;
         regs_ff.max_width     <= RESET_MAX_WIDTH;
         regs_ff.frame_gap     <= RESET_FRAME_GAP;
         regs_ff.loss_timeout  <= RESET_LOSS_TIMEOUT;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign regs = regs_ff;

endmodule

@@ hdl/ppmd_input_stage.sv @@
// Input register of the PPM decoder: holds one sample until the result
// register can take it. Depends on ppmd_pkg.
module ppmd_input_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  ppmd_pkg::req_item_type req_item,
   input  logic                   down_open,
   output logic                   item_valid,
   output ppmd_pkg::req_item_type item,
   output logic                   item_move
);
   import ppmd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign item_move = valid_ff & down_open;
   assign req_stall = valid_ff & ~down_open;
   assign take      = req_valid & ~req_stall;
   assign valid_in  = take | (valid_ff & ~item_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hdl/ppmd_core.sv @@
// Decoder state and per-tick update: edge detect, gap and age counters,
// slot store and channel read-back. Depends on ppmd_pkg.
module ppmd_core #(
   parameter int MAX_CHANNELS = 16,
   parameter int GAP_BITS     = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  ppmd_pkg::req_item_type item,
   input  ppmd_pkg::csr_regs_type regs,
   output ppmd_pkg::rsp_item_type result
);
   import ppmd_pkg::*;

   localparam int SLOT_BITS = $clog2(MAX_CHANNELS + 1);
   localparam int CW        = (SLOT_BITS > COUNT_BITS) ? SLOT_BITS : COUNT_BITS;
   localparam int RW        = (SLOT_BITS > READ_BITS) ? SLOT_BITS : READ_BITS;
   localparam int TW        = (GAP_BITS > TIME_BITS) ? GAP_BITS : TIME_BITS;
   localparam logic [GAP_BITS-1:0] GAP_MAX = {GAP_BITS{1'b1}};
   localparam logic [CW-1:0] MAX_CW = CW'(MAX_CHANNELS);

   logic                  prev_level_ff;
   logic [GAP_BITS-1:0]   edge_gap_ff, edge_gap_in;
   logic [GAP_BITS-1:0]   frame_age_ff, frame_age_in;
   logic [SLOT_BITS-1:0]  slot_ff, slot_in;
   logic [WIDTH_BITS-1:0] widths_ff [MAX_CHANNELS];
   logic                  ready_ff, ready_in;

   logic [GAP_BITS-1:0]   gap_inc, age_inc;
   logic [CW-1:0]         count_cw;
   logic [SLOT_BITS-1:0]  count;
   logic [SLOT_BITS-1:0]  slot_next;
   logic [TW-1:0]         gap_ext;
   logic                  rise, is_sync, in_range, store, last_slot, ready_now;
   logic [RW-1:0]         read_ext;
   logic [WIDTH_BITS-1:0] read_value;
   logic [WIDTH_BITS-1:0] gap_width;

   assign gap_inc  = (edge_gap_ff == GAP_MAX) ? edge_gap_ff : edge_gap_ff + 1'b1;
   assign age_inc  = (frame_age_ff == GAP_MAX) ? frame_age_ff : frame_age_ff + 1'b1;
   assign count_cw = CW'(regs.channel_count);
   assign count    = (count_cw > MAX_CW) ? SLOT_BITS'(MAX_CHANNELS)
                                         : SLOT_BITS'(count_cw);
   assign gap_ext   = TW'(gap_inc);
   assign gap_width = gap_inc[WIDTH_BITS-1:0];

   assign rise     = item.line_level & ~prev_level_ff;
   assign is_sync  = rise & (gap_ext > TW'(regs.frame_gap));
   assign in_range = (gap_ext >= TW'(regs.min_width)) & (gap_ext <= TW'(regs.max_width));
   assign store    = rise & ~is_sync & (slot_ff < count) & in_range;
   assign slot_next = slot_ff + 1'b1;
   assign last_slot = store & (slot_next == count);

   assign edge_gap_in  = rise ? '0 : gap_inc;
   assign frame_age_in = (is_sync | last_slot) ? '0 : age_inc;
   assign slot_in      = is_sync ? '0 : (store ? slot_next : slot_ff);
   assign ready_now    = rise | ready_ff;
   assign ready_in     = item.acknowledge ? 1'b0 : ready_now;

   assign read_ext = RW'(item.read_channel);

   always_comb begin
      read_value = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (read_ext == RW'(i)) begin
            read_value = (store && slot_ff == SLOT_BITS'(i)) ? gap_width : widths_ff[i];
         end
      end
      if (read_ext >= RW'(count)) begin
         read_value = '0;
      end
   end

   always_comb begin
      result.ready_res    = ready_now;
      result.signal_lost  = TW'(frame_age_in) > TW'(regs.loss_timeout);
      result.read_value   = read_value;
      result.width_stored = store;
      result.sync_seen    = is_sync;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= 1'b0;
         edge_gap_ff   <= '0;
         frame_age_ff  <= '0;
         slot_ff       <= '0;
         ready_ff      <= 1'b0;
      end else if (step) begin
         prev_level_ff <= item.line_level;
         edge_gap_ff   <= edge_gap_in;
         frame_age_ff  <= frame_age_in;
         slot_ff       <= slot_in;
         ready_ff      <= ready_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (reset) begin
            widths_ff[i] <= '0;
         end else if (step && store && slot_ff == SLOT_BITS'(i)) begin
            widths_ff[i] <= gap_width;
         end
      end
   end

endmodule

@@ hdl/ppmd_output_stage.sv @@
// Result register of the PPM decoder; holds a result while rsp_stall is high.
// Depends on ppmd_pkg.
module ppmd_output_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ppmd_pkg::rsp_item_type result,
   output logic                   open,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output ppmd_pkg::rsp_item_type rsp_item
);
   import ppmd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign open     = ~valid_ff | ~rsp_stall;
   assign valid_in = load | (valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

@@ hdl/ppm_pulse_train_decoder.sv @@
// PPM pulse train decoder. Each transfer on req_ carries one line sample per
// timebase tick and produces exactly one transfer on rsp_. The block takes one
// sample every clock while req_stall is low; each result passes the input
// register, then the result register, before it shows on rsp_, and req_stall
// rises only while both registers are full and rsp_stall is high. Channel
// widths are kept in a register file written and read in the same tick, so
// read_value already shows a width stored by that tick. Configuration is
// written through csr_.
module ppm_pulse_train_decoder #(
   parameter int MAX_CHANNELS = 16,
   parameter int GAP_BITS     = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_line_level,
   input  logic [ppmd_pkg::READ_BITS-1:0]      req_read_channel,
   input  logic                                req_acknowledge,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ready_res,
   output logic                                rsp_signal_lost,
   output logic [ppmd_pkg::WIDTH_BITS-1:0]     rsp_read_value,
   output logic                                rsp_width_stored,
   output logic                                rsp_sync_seen,
   input  logic                                csr_write_enable,
   input  logic [ppmd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [ppmd_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import ppmd_pkg::*;

   csr_regs_type regs;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         item_valid;
   logic         item_move;
   logic         down_open;

   assign req_item.line_level   = req_line_level;
   assign req_item.read_channel = req_read_channel;
   assign req_item.acknowledge  = req_acknowledge;

   ppmd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .regs             (regs)
   );

   ppmd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .down_open  (down_open),
      .item_valid (item_valid),
      .item       (item),
      .item_move  (item_move)
   );

   ppmd_core #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .GAP_BITS     (GAP_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (item_move & item_valid),
      .item   (item),
      .regs   (regs),
      .result (result)
   );

   ppmd_output_stage u_output (
      .clock     (clock),
      .reset     (reset),
      .load      (item_move),
      .result    (result),
      .open      (down_open),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   assign rsp_ready_res    = rsp_item.ready_res;
   assign rsp_signal_lost  = rsp_item.signal_lost;
   assign rsp_read_value   = rsp_item.read_value;
   assign rsp_width_stored = rsp_item.width_stored;
   assign rsp_sync_seen    = rsp_item.sync_seen;

endmodule

@@ hdl/ppmd_checker.sv @@
// Port-level checks of the PPM decoder, bound to the top level.
// Depends only on the top level's ports.
module ppmd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_ready_res,
   input logic [15:0] rsp_read_value,
   input logic        rsp_width_stored,
   input logic        rsp_sync_seen
);

   logic [2:0] open_ff;
   logic [2:0] open_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid & ~req_stall;
   assign rsp_xfer = rsp_valid & ~rsp_stall;

   always_comb begin
      open_in = open_ff;
      if (req_xfer && !rsp_xfer) begin
         open_in = open_ff + 3'd1;
      end else if (rsp_xfer && !req_xfer) begin
         open_in = open_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= 3'd0;
      end else begin
         open_ff <= open_in;
      end
   end

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value))
      else $error("held result dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_width_stored && rsp_sync_seen))
      else $error("edge both stored and synced");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_width_stored || rsp_sync_seen) |-> rsp_ready_res)
      else $error("edge reported without ready flag");

   assert property (@(posedge clock) disable iff (reset)
      (open_ff <= 3'd2) && (open_ff != 3'd0 || !rsp_valid))
      else $error("outstanding transfer count out of range");

endmodule

bind ppm_pulse_train_decoder ppmd_checker u_ppmd_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_ready_res    (rsp_ready_res),
   .rsp_read_value   (rsp_read_value),
   .rsp_width_stored (rsp_width_stored),
   .rsp_sync_seen    (rsp_sync_seen)
);
